// ===== hw/rtl/aetd_pkg.sv =====
// Shared types and constants of the escape sequence decoder.
// Holds command codes, sequence phases, byte classes and the
// controller/datapath interface structs. No dependencies.
package aetd_pkg;

    // Result field widths and the per-byte result limit
    localparam int ARG_W     = 9;
    localparam int CMD_W     = 5;
    localparam int RES_LIMIT = 8;
    localparam int EMIT_W    = 3;

    // Byte values
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LBRK   = "[";
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_0      = "0";
    localparam logic [7:0] CH_9      = "9";
    localparam logic [7:0] CH_FIN_R  = "r";
    localparam logic [7:0] CH_FIN_H  = "H";
    localparam logic [7:0] CH_FIN_F  = "f";
    localparam logic [7:0] CH_FIN_A  = "A";
    localparam logic [7:0] CH_FIN_B  = "B";
    localparam logic [7:0] CH_FIN_C  = "C";
    localparam logic [7:0] CH_FIN_D  = "D";
    localparam logic [7:0] CH_FIN_M  = "m";
    localparam logic [7:0] CH_FIN_J  = "J";
    localparam logic [7:0] CH_FIN_K  = "K";
    localparam logic [7:0] CH_FIN_L  = "L";
    localparam logic [7:0] CH_FIN_DL = "M";

    // Display commands
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT_CHAR      = 5'd0,
        CMD_CR            = 5'd1,
        CMD_LF            = 5'd2,
        CMD_LEFT          = 5'd3,
        CMD_MOVE          = 5'd4,
        CMD_HOME          = 5'd5,
        CMD_ERASE_EOS     = 5'd6,
        CMD_ERASE_SCREEN  = 5'd7,
        CMD_ERASE_EOL     = 5'd8,
        CMD_ERASE_LINE    = 5'd9,
        CMD_INS_LINE      = 5'd10,
        CMD_DEL_LINE      = 5'd11,
        CMD_ATTR_NORMAL   = 5'd12,
        CMD_ATTR_BOLD     = 5'd13,
        CMD_ATTR_BLINK    = 5'd14,
        CMD_ATTR_REVERSE  = 5'd15,
        CMD_DROPPED       = 5'd16
    } cmd_t;

    // Sequence phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC,
        PH_FIRST,
        PH_COLLECT,
        PH_STALL,
        PH_ATTR
    } phase_t;

    // Final byte kinds
    typedef enum logic [3:0] {
        FIN_NONE,
        FIN_CONSUME,
        FIN_LEFT,
        FIN_CURSOR,
        FIN_ERASE_SCR,
        FIN_ERASE_LN,
        FIN_INS,
        FIN_DEL,
        FIN_ATTR
    } fin_t;

    // Attribute kinds carried per stored value
    typedef enum logic [1:0] {
        ATTR_NORMAL,
        ATTR_BOLD,
        ATTR_BLINK,
        ATTR_REVERSE
    } attr_t;

    // Argument source of a loaded result
    typedef enum logic [1:0] {
        ARG_ZERO,
        ARG_CHAR,
        ARG_MOVE
    } argsel_t;

    typedef struct packed {
        logic is_esc;
        logic is_cr;
        logic is_lf;
        logic is_lbrk;
        logic is_digit;
        logic is_semi;
        fin_t fin;
    } chr_class_t;

    // Datapath to controller
    typedef struct packed {
        chr_class_t cls;
        logic       count_zero;
        logic       count_two;
        logic       first_zero;
        logic       first_two;
        logic       attr_any;
        logic       attr_last;
        logic       out_free;
    } dp_status_t;

    // Controller to datapath
    typedef struct packed {
        logic    seq_clear;
        logic    digit;
        logic    run_end;
        logic    out_load;
        cmd_t    out_cmd;
        argsel_t arg_sel;
        logic    attr_start;
        logic    attr_step;
    } ctrl_cmd_t;

    // Map a byte to its final kind
    function automatic fin_t fin_of(input logic [7:0] c);
        fin_t f;
        case (c)
            CH_FIN_R, CH_FIN_F, CH_FIN_A, CH_FIN_B, CH_FIN_C: f = FIN_CONSUME;
            CH_FIN_D:  f = FIN_LEFT;
            CH_FIN_H:  f = FIN_CURSOR;
            CH_FIN_J:  f = FIN_ERASE_SCR;
            CH_FIN_K:  f = FIN_ERASE_LN;
            CH_FIN_L:  f = FIN_INS;
            CH_FIN_DL: f = FIN_DEL;
            CH_FIN_M:  f = FIN_ATTR;
            default:   f = FIN_NONE;
        endcase
        return f;
    endfunction

endpackage

// ===== hw/rtl/ansi_escape_terminal_decoder_unit.sv =====
// Top level of the escape sequence decoder: aetd_ctrl plus aetd_dpath.
// Depends on aetd_pkg, aetd_ctrl and aetd_dpath.

// Decodes console output bytes into display commands, one byte per beat on
// s_*, one command per beat on m_* with m_last on the final command of a
// byte. Every byte, whether or not it gives a command, needs the single
// result register free (empty, or drained in the same cycle), so a stalled
// m_ready holds off s_ready. After an 'm' final with one or more of the values
// 0, 1, 5 or 7, the attribute walk owns the result register and loads one
// attribute command each time it is free (at most eight); no byte is taken in
// that time. Values saturate at VALUE_MAX and runs past MAX_PARAMS are
// ignored. No clearing pass after reset.
module ansi_escape_terminal_decoder_unit #(
    parameter int MAX_PARAMS = 8,
    parameter int VALUE_MAX  = 255
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_char_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [aetd_pkg::CMD_W-1:0]         m_command,
    output logic signed [aetd_pkg::ARG_W-1:0]  m_arg_a,
    output logic signed [aetd_pkg::ARG_W-1:0]  m_arg_b,
    output logic                               m_last
);
    import aetd_pkg::*;

    dp_status_t stat;
    ctrl_cmd_t  cmd;

    aetd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    aetd_dpath #(
        .MAX_PARAMS (MAX_PARAMS),
        .VALUE_MAX  (VALUE_MAX)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_char_in (s_char_in),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_command (m_command),
        .m_arg_a   (m_arg_a),
        .m_arg_b   (m_arg_b),
        .m_last    (m_last)
    );

    // A byte is never taken while an untaken result sits in the register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> (!m_valid || m_ready))
        else $error("byte taken while result register blocked");

    // Only attribute commands may be followed by more commands of the same byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_command != CMD_ATTR_NORMAL) && (m_command != CMD_ATTR_BOLD)
         && (m_command != CMD_ATTR_BLINK) && (m_command != CMD_ATTR_REVERSE))
        |-> m_last)
        else $error("non-attribute command without last");

    // A result without m_last is always followed by another valid result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |=> m_valid)
        else $error("attribute burst broken off");

endmodule

// ===== hw/rtl/aetd_ctrl.sv =====
// Sequence controller of the escape sequence decoder.
// Tracks the sequence phase and issues commands to aetd_dpath.
// Depends on aetd_pkg.
module aetd_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  aetd_pkg::dp_status_t   stat,
    output aetd_pkg::ctrl_cmd_t    cmd
);
    import aetd_pkg::*;

    phase_t phase_reg;
    phase_t phase_next;
    logic   accept;

    // Take a beat only when the output slot can be loaded
    assign s_ready = (phase_reg != PH_ATTR) && stat.out_free;
    assign accept  = s_valid && s_ready;

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE: begin
                if (accept && stat.cls.is_esc) begin
                    phase_next = PH_ESC;
                end
            end
            PH_ESC: begin
                if (accept) begin
                    if (stat.cls.is_esc) begin
                        phase_next = PH_IDLE;
                    end else if (stat.cls.is_lbrk) begin
                        phase_next = PH_FIRST;
                    end else begin
                        phase_next = PH_STALL;
                    end
                end
            end
            PH_FIRST, PH_COLLECT: begin
                if (accept) begin
                    if (stat.cls.is_esc) begin
                        phase_next = PH_IDLE;
                    end else if (stat.cls.is_digit || stat.cls.is_semi) begin
                        phase_next = PH_COLLECT;
                    end else if (stat.cls.fin == FIN_ATTR) begin
                        phase_next = (!stat.count_zero && stat.attr_any) ? PH_ATTR : PH_IDLE;
                    end else if (stat.cls.fin != FIN_NONE) begin
                        phase_next = PH_IDLE;
                    end else if (phase_reg == PH_FIRST) begin
                        phase_next = PH_COLLECT;
                    end else begin
                        phase_next = PH_STALL;
                    end
                end
            end
            PH_STALL: begin
                if (accept && stat.cls.is_esc) begin
                    phase_next = PH_IDLE;
                end
            end
            PH_ATTR: begin
                if (stat.out_free && stat.attr_last) begin
                    phase_next = PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        cmd            = '0;
        cmd.out_cmd    = CMD_PUT_CHAR;
        cmd.arg_sel    = ARG_ZERO;
        case (phase_reg)
            PH_IDLE: begin
                if (accept) begin
                    if (stat.cls.is_esc) begin
                        cmd.seq_clear = 1'b1;
                    end else if (stat.cls.is_cr) begin
                        cmd.out_load = 1'b1;
                        cmd.out_cmd  = CMD_CR;
                    end else if (stat.cls.is_lf) begin
                        cmd.out_load = 1'b1;
                        cmd.out_cmd  = CMD_LF;
                    end else begin
                        cmd.out_load = 1'b1;
                        cmd.out_cmd  = CMD_PUT_CHAR;
                        cmd.arg_sel  = ARG_CHAR;
                    end
                end
            end
            PH_ESC, PH_STALL: begin
                if (accept && stat.cls.is_esc) begin
                    cmd.out_load = 1'b1;
                    cmd.out_cmd  = CMD_DROPPED;
                end
            end
            PH_FIRST, PH_COLLECT: begin
                if (accept) begin
                    if (stat.cls.is_esc) begin
                        cmd.out_load = 1'b1;
                        cmd.out_cmd  = CMD_DROPPED;
                    end else if (stat.cls.is_digit) begin
                        cmd.digit = 1'b1;
                    end else if (stat.cls.is_semi) begin
                        cmd.run_end = 1'b1;
                    end else begin
                        case (stat.cls.fin)
                            FIN_LEFT: begin
                                cmd.out_load = 1'b1;
                                cmd.out_cmd  = CMD_LEFT;
                            end
                            FIN_CURSOR: begin
                                if (stat.count_two) begin
                                    cmd.out_load = 1'b1;
                                    cmd.out_cmd  = CMD_MOVE;
                                    cmd.arg_sel  = ARG_MOVE;
                                end else if (stat.count_zero) begin
                                    cmd.out_load = 1'b1;
                                    cmd.out_cmd  = CMD_HOME;
                                end
                            end
                            FIN_ERASE_SCR: begin
                                if (stat.count_zero || stat.first_zero) begin
                                    cmd.out_load = 1'b1;
                                    cmd.out_cmd  = CMD_ERASE_EOS;
                                end else if (stat.first_two) begin
                                    cmd.out_load = 1'b1;
                                    cmd.out_cmd  = CMD_ERASE_SCREEN;
                                end
                            end
                            FIN_ERASE_LN: begin
                                if (stat.count_zero || stat.first_zero) begin
                                    cmd.out_load = 1'b1;
                                    cmd.out_cmd  = CMD_ERASE_EOL;
                                end else if (stat.first_two) begin
                                    cmd.out_load = 1'b1;
                                    cmd.out_cmd  = CMD_ERASE_LINE;
                                end
                            end
                            FIN_INS: begin
                                cmd.out_load = 1'b1;
                                cmd.out_cmd  = CMD_INS_LINE;
                            end
                            FIN_DEL: begin
                                cmd.out_load = 1'b1;
                                cmd.out_cmd  = CMD_DEL_LINE;
                            end
                            FIN_ATTR: begin
                                if (stat.count_zero) begin
                                    cmd.out_load = 1'b1;
                                    cmd.out_cmd  = CMD_ATTR_NORMAL;
                                end else if (stat.attr_any) begin
                                    cmd.attr_start = 1'b1;
                                end
                            end
                            FIN_CONSUME: begin
                            end
                            FIN_NONE: begin
                                // stray byte after '[' only splits digit runs
                                if (phase_reg == PH_FIRST) begin
                                    cmd.run_end = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            PH_ATTR: begin
                if (stat.out_free) begin
                    cmd.attr_step = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Phase register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== hw/rtl/aetd_dpath.sv =====
// Datapath of the escape sequence decoder: byte classing, value
// collection, attribute list walk and the result register.
// Depends on aetd_pkg.
module aetd_dpath #(
    parameter int MAX_PARAMS = 8,
    parameter int VALUE_MAX  = 255
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [7:0]                         s_char_in,
    input  logic                               m_ready,
    input  aetd_pkg::ctrl_cmd_t                cmd,
    output aetd_pkg::dp_status_t               stat,
    output logic                               m_valid,
    output logic [aetd_pkg::CMD_W-1:0]         m_command,
    output logic signed [aetd_pkg::ARG_W-1:0]  m_arg_a,
    output logic signed [aetd_pkg::ARG_W-1:0]  m_arg_b,
    output logic                               m_last
);
    import aetd_pkg::*;

    localparam int VW    = $clog2(VALUE_MAX + 1);
    localparam int SUM_W = VW + 4;
    localparam int CNT_W = $clog2(MAX_PARAMS + 1);
    localparam int IDX_W = $clog2(MAX_PARAMS);
    localparam int EW    = (VW + 1 > ARG_W) ? VW + 1 : ARG_W;

    // Attribute kind of a value; flag is low for values that give no command
    function automatic logic [2:0] attr_of(input logic [VW-1:0] v);
        logic [2:0] r;
        r = {1'b0, ATTR_NORMAL};
        if (v == VW'(0)) begin
            r = {1'b1, ATTR_NORMAL};
        end else if (v == VW'(1)) begin
            r = {1'b1, ATTR_BOLD};
        end else if (v == VW'(5)) begin
            r = {1'b1, ATTR_BLINK};
        end else if (v == VW'(7)) begin
            r = {1'b1, ATTR_REVERSE};
        end
        return r;
    endfunction

    logic                    in_run_reg, in_run_next;
    logic                    extra_reg, extra_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [VW-1:0]           acc_reg, acc_next;
    logic [VW-1:0]           val_reg [2];
    logic [MAX_PARAMS-1:0]   attr_flag_reg;
    attr_t                   attr_code_reg [MAX_PARAMS];
    logic [MAX_PARAMS-1:0]   emask_reg, emask_next;
    logic [EMIT_W-1:0]       emit_cnt_reg, emit_cnt_next;

    logic                    out_valid_reg;
    cmd_t                    cmd_reg;
    logic signed [ARG_W-1:0] arg_a_reg, arg_b_reg;
    logic                    last_reg;

    logic [3:0]              digit;
    logic [SUM_W-1:0]        acc_ext, sum;
    logic [VW-1:0]           acc_sat;
    logic                    has_room;
    logic                    wr_en;
    logic [CNT_W-1:0]        wr_idx;
    logic [VW-1:0]           wr_val;
    logic [2:0]              wr_attr;
    logic [MAX_PARAMS-1:0]   below;
    logic [MAX_PARAMS-1:0]   lowest, rest;
    logic [1:0]              sel_code;
    attr_t                   sel_attr;
    cmd_t                    attr_cmd;
    logic                    out_free;
    logic [EW-1:0]           row_m1, col_m1;

    // Classify the incoming byte
    assign stat.cls.is_esc   = (s_char_in == CH_ESC);
    assign stat.cls.is_cr    = (s_char_in == CH_CR);
    assign stat.cls.is_lf    = (s_char_in == CH_LF);
    assign stat.cls.is_lbrk  = (s_char_in == CH_LBRK);
    assign stat.cls.is_digit = (s_char_in >= CH_0) && (s_char_in <= CH_9);
    assign stat.cls.is_semi  = (s_char_in == CH_SEMI);
    assign stat.cls.fin      = fin_of(s_char_in);

    // Decimal accumulate with saturation
    assign digit    = 4'(s_char_in - CH_0);
    assign acc_ext  = SUM_W'(acc_reg);
    assign sum      = (acc_ext << 3) + (acc_ext << 1) + SUM_W'(digit);
    assign acc_sat  = (sum > SUM_W'(VALUE_MAX)) ? VW'(VALUE_MAX) : sum[VW-1:0];
    assign has_room = (count_reg != CNT_W'(MAX_PARAMS));

    // Value collection
    always_comb begin
        in_run_next = in_run_reg;
        extra_next  = extra_reg;
        count_next  = count_reg;
        acc_next    = acc_reg;
        wr_en       = 1'b0;
        wr_idx      = count_reg;
        wr_val      = acc_sat;
        if (cmd.seq_clear) begin
            in_run_next = 1'b0;
            extra_next  = 1'b0;
            count_next  = '0;
        end else if (cmd.run_end) begin
            in_run_next = 1'b0;
        end else if (cmd.digit) begin
            if (!in_run_reg) begin
                in_run_next = 1'b1;
                if (has_room) begin
                    wr_en      = 1'b1;
                    wr_idx     = count_reg;
                    wr_val     = VW'(digit);
                    acc_next   = VW'(digit);
                    count_next = count_reg + CNT_W'(1);
                    extra_next = 1'b0;
                end else begin
                    extra_next = 1'b1;
                end
            end else if (!extra_reg && (count_reg != '0)) begin
                wr_en    = 1'b1;
                wr_idx   = count_reg - CNT_W'(1);
                wr_val   = acc_sat;
                acc_next = acc_sat;
            end
        end
    end

    assign wr_attr = attr_of(wr_val);

    // Store values and their attribute kinds
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (wr_en) begin
            attr_code_reg[wr_idx[IDX_W-1:0]] <= attr_t'(wr_attr[1:0]);
            if (wr_idx == CNT_W'(0)) begin
                val_reg[0] <= wr_val;
            end
            if (wr_idx == CNT_W'(1)) begin
                val_reg[1] <= wr_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_run_reg    <= 1'b0;
            extra_reg     <= 1'b0;
            count_reg     <= '0;
            attr_flag_reg <= '0;
        end else begin
            in_run_reg <= in_run_next;
            extra_reg  <= extra_next;
            count_reg  <= count_next;
            if (wr_en) begin
                attr_flag_reg[wr_idx[IDX_W-1:0]] <= wr_attr[2];
            end
        end
    end

    // Attribute list walk: lowest pending entry first
    always_comb begin
        for (int i = 0; i < MAX_PARAMS; i++) begin
            below[i] = (CNT_W'(i) < count_reg);
        end
    end

    assign lowest = emask_reg & (~emask_reg + MAX_PARAMS'(1));
    assign rest   = emask_reg & ~lowest;

    always_comb begin
        sel_code = '0;
        for (int i = 0; i < MAX_PARAMS; i++) begin
            sel_code = sel_code | ({2{lowest[i]}} & attr_code_reg[i]);
        end
    end

    assign sel_attr = attr_t'(sel_code);

    always_comb begin
        case (sel_attr)
            ATTR_NORMAL:  attr_cmd = CMD_ATTR_NORMAL;
            ATTR_BOLD:    attr_cmd = CMD_ATTR_BOLD;
            ATTR_BLINK:   attr_cmd = CMD_ATTR_BLINK;
            ATTR_REVERSE: attr_cmd = CMD_ATTR_REVERSE;
            default:      attr_cmd = CMD_ATTR_NORMAL;
        endcase
    end

    always_comb begin
        emask_next    = emask_reg;
        emit_cnt_next = emit_cnt_reg;
        if (cmd.attr_start) begin
            emask_next    = attr_flag_reg & below;
            emit_cnt_next = '0;
        end else if (cmd.attr_step) begin
            emask_next    = rest;
            emit_cnt_next = emit_cnt_reg + EMIT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emask_reg    <= '0;
            emit_cnt_reg <= '0;
        end else begin
            emask_reg    <= emask_next;
            emit_cnt_reg <= emit_cnt_next;
        end
    end

    // Cursor move arguments, value minus one
    assign row_m1 = EW'(val_reg[0]) - EW'(1);
    assign col_m1 = EW'(val_reg[1]) - EW'(1);

    // Result register
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            cmd_reg  <= cmd.out_cmd;
            last_reg <= 1'b1;
            case (cmd.arg_sel)
                ARG_CHAR: begin
                    arg_a_reg <= signed'({1'b0,
                        (s_char_in == CH_DEL) ? CH_SPACE : s_char_in});
                    arg_b_reg <= '0;
                end
                ARG_MOVE: begin
                    arg_a_reg <= signed'(row_m1[ARG_W-1:0]);
                    arg_b_reg <= signed'(col_m1[ARG_W-1:0]);
                end
                default: begin
                    arg_a_reg <= '0;
                    arg_b_reg <= '0;
                end
            endcase
        end else if (cmd.attr_step) begin
            cmd_reg   <= attr_cmd;
            last_reg  <= stat.attr_last;
            arg_a_reg <= '0;
            arg_b_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load || cmd.attr_step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Status to the controller
    assign stat.count_zero = (count_reg == '0);
    assign stat.count_two  = (count_reg == CNT_W'(2));
    assign stat.first_zero = (val_reg[0] == '0);
    assign stat.first_two  = (val_reg[0] == VW'(2));
    assign stat.attr_any   = |(attr_flag_reg & below);
    assign stat.attr_last  = (rest == '0) || (emit_cnt_reg == EMIT_W'(RES_LIMIT - 1));
    assign stat.out_free   = out_free;

    assign m_valid   = out_valid_reg;
    assign m_command = cmd_reg;
    assign m_arg_a   = arg_a_reg;
    assign m_arg_b   = arg_b_reg;
    assign m_last    = last_reg;

endmodule

// ===== tb/sv/aetd_cmd_check.sv =====
`timescale 1ns / 100ps
// Command stream checker for the escape sequence decoder testbench.
// Predicts display commands from accepted bytes and compares every result beat.
// Depends on aetd_pkg.
module aetd_cmd_check #(
    parameter int MAX_PARAMS = 8,
    parameter int VALUE_MAX  = 255
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [7:0]                         s_char_in,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [aetd_pkg::CMD_W-1:0]         m_command,
    input  logic signed [aetd_pkg::ARG_W-1:0]  m_arg_a,
    input  logic signed [aetd_pkg::ARG_W-1:0]  m_arg_b,
    input  logic                               m_last,
    output int                                 fail_count,
    output int                                 cmds_waiting
);
    import aetd_pkg::*;

    // Parameter values that select an attribute or an erase extent
    localparam int SGR_RESET   = 0;
    localparam int SGR_BOLD    = 1;
    localparam int SGR_BLINK   = 5;
    localparam int SGR_REVERSE = 7;
    localparam int ERASE_TO_END = 0;
    localparam int ERASE_ALL    = 2;

    typedef struct packed {
        cmd_t             cmd;
        logic [ARG_W-1:0] arg_a;
        logic [ARG_W-1:0] arg_b;
        logic             last;
    } disp_cmd_t;

    disp_cmd_t expected_cmds[$];
    disp_cmd_t byte_cmds[$];

    // Shadow of the decoder's sequence state
    phase_t seq_ph;
    bit     digit_run;
    bit     run_over;
    int     val_cnt;
    int     vals[MAX_PARAMS];

    int errs = 0;
    int waiting_q = 0;

    assign fail_count   = errs;
    assign cmds_waiting = waiting_q;

    function automatic bit is_final_byte(input logic [7:0] c);
        case (c)
            CH_FIN_R, CH_FIN_H, CH_FIN_F, CH_FIN_A, CH_FIN_B, CH_FIN_C,
            CH_FIN_D, CH_FIN_M, CH_FIN_J, CH_FIN_K, CH_FIN_L, CH_FIN_DL: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Queue one command for the current byte, capped at the per-byte limit
    function automatic void add_cmd(input cmd_t cmd, input int a, input int b);
        disp_cmd_t r;
        if (byte_cmds.size() < RES_LIMIT) begin
            r.cmd   = cmd;
            r.arg_a = a[ARG_W-1:0];
            r.arg_b = b[ARG_W-1:0];
            r.last  = 1'b0;
            byte_cmds = {byte_cmds, r};
        end
    endfunction

    // Accumulate one decimal digit, saturating and dropping surplus runs
    function automatic void take_digit(input int d);
        int v;
        if (!digit_run) begin
            digit_run = 1'b1;
            if (val_cnt < MAX_PARAMS) begin
                vals[val_cnt] = d;
                val_cnt++;
                run_over = 1'b0;
            end else begin
                run_over = 1'b1;
            end
        end else if (!run_over && val_cnt > 0) begin
            v = vals[val_cnt-1] * 10 + d;
            vals[val_cnt-1] = (v > VALUE_MAX) ? VALUE_MAX : v;
        end
    endfunction

    // Turn a final byte and the collected values into commands
    function automatic void close_seq(input logic [7:0] c);
        int i;
        case (c)
            CH_FIN_D: add_cmd(CMD_LEFT, 0, 0);
            CH_FIN_H: begin
                if (val_cnt == 2)
                    add_cmd(CMD_MOVE, vals[0] - 1, vals[1] - 1);
                else if (val_cnt == 0)
                    add_cmd(CMD_HOME, 0, 0);
            end
            CH_FIN_J: begin
                if (val_cnt == 0 || vals[0] == ERASE_TO_END)
                    add_cmd(CMD_ERASE_EOS, 0, 0);
                else if (vals[0] == ERASE_ALL)
                    add_cmd(CMD_ERASE_SCREEN, 0, 0);
            end
            CH_FIN_K: begin
                if (val_cnt == 0 || vals[0] == ERASE_TO_END)
                    add_cmd(CMD_ERASE_EOL, 0, 0);
                else if (vals[0] == ERASE_ALL)
                    add_cmd(CMD_ERASE_LINE, 0, 0);
            end
            CH_FIN_L:  add_cmd(CMD_INS_LINE, 0, 0);
            CH_FIN_DL: add_cmd(CMD_DEL_LINE, 0, 0);
            CH_FIN_M: begin
                if (val_cnt == 0)
                    add_cmd(CMD_ATTR_NORMAL, 0, 0);
                for (i = 0; i < val_cnt; i++) begin
                    case (vals[i])
                        SGR_RESET:   add_cmd(CMD_ATTR_NORMAL, 0, 0);
                        SGR_BOLD:    add_cmd(CMD_ATTR_BOLD, 0, 0);
                        SGR_BLINK:   add_cmd(CMD_ATTR_BLINK, 0, 0);
                        SGR_REVERSE: add_cmd(CMD_ATTR_REVERSE, 0, 0);
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        seq_ph = PH_IDLE;
    endfunction

    // Advance the shadow state by one byte and queue what it yields
    function automatic void decode_byte(input logic [7:0] c);
        disp_cmd_t r;
        byte_cmds.delete();
        if (seq_ph == PH_IDLE) begin
            if (c == CH_CR) begin
                add_cmd(CMD_CR, 0, 0);
            end else if (c == CH_LF) begin
                add_cmd(CMD_LF, 0, 0);
            end else if (c == CH_ESC) begin
                seq_ph    = PH_ESC;
                digit_run = 1'b0;
                val_cnt   = 0;
                run_over  = 1'b0;
            end else begin
                add_cmd(CMD_PUT_CHAR, (c == CH_DEL) ? int'(CH_SPACE) : int'(c), 0);
            end
        end else if (c == CH_ESC) begin
            add_cmd(CMD_DROPPED, 0, 0);
            seq_ph = PH_IDLE;
        end else if (seq_ph == PH_ESC) begin
            seq_ph = (c == CH_LBRK) ? PH_FIRST : PH_STALL;
        end else if (seq_ph == PH_FIRST || seq_ph == PH_COLLECT) begin
            if (c >= CH_0 && c <= CH_9) begin
                take_digit(int'(c - CH_0));
                seq_ph = PH_COLLECT;
            end else if (c == CH_SEMI) begin
                digit_run = 1'b0;
                seq_ph    = PH_COLLECT;
            end else if (is_final_byte(c)) begin
                close_seq(c);
            end else if (seq_ph == PH_FIRST) begin
                // stray byte right after the bracket only ends a digit run
                digit_run = 1'b0;
                seq_ph    = PH_COLLECT;
            end else begin
                seq_ph = PH_STALL;
            end
        end else begin
            seq_ph = PH_STALL;
        end
        while (byte_cmds.size() > 0) begin
            r = byte_cmds.pop_front();
            r.last = (byte_cmds.size() == 0);
            expected_cmds = {expected_cmds, r};
        end
    endfunction

    // Compare one result beat against the oldest expectation
    function automatic void check_beat();
        disp_cmd_t e;
        if (expected_cmds.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual cmd %0d a %0d b %0d last %0b",
                     $time, m_command, m_arg_a, m_arg_b, m_last);
            errs++;
            return;
        end
        e = expected_cmds.pop_front();
        if (m_command !== e.cmd) begin
            $display("%0t: command expected %0d actual %0d", $time, e.cmd, m_command);
            errs++;
        end
        if (m_arg_a !== e.arg_a) begin
            $display("%0t: arg_a expected %0d actual %0d", $time, $signed(e.arg_a), m_arg_a);
            errs++;
        end
        if (m_arg_b !== e.arg_b) begin
            $display("%0t: arg_b expected %0d actual %0d", $time, $signed(e.arg_b), m_arg_b);
            errs++;
        end
        if (m_last !== e.last) begin
            $display("%0t: last expected %0b actual %0b", $time, e.last, m_last);
            errs++;
        end
    endfunction

    // Watch both channels; input beat is predicted before the result beat is checked
    always @(posedge aclk) begin
        if (!aresetn) begin
            seq_ph    = PH_IDLE;
            digit_run = 1'b0;
            run_over  = 1'b0;
            val_cnt   = 0;
            expected_cmds.delete();
        end else begin
            if (s_valid && s_ready)
                decode_byte(s_char_in);
            if (m_valid && m_ready)
                check_beat();
        end
        waiting_q <= expected_cmds.size();
    end

endmodule

// ===== tb/sv/tb_ansi_escape_terminal_decoder_unit.sv =====
`timescale 1ns / 100ps
// Top of the escape sequence decoder testbench: clock, reset, byte stimulus,
// result-side stalls and the verdict. Depends on aetd_pkg, aetd_cmd_check and
// ansi_escape_terminal_decoder_unit.
module tb_ansi_escape_terminal_decoder_unit;
    import aetd_pkg::*;

    localparam int MAX_PARAMS  = 8;
    localparam int VALUE_MAX   = 255;
    localparam int BYTE_TARGET = 310;
    localparam int TAIL_CYCLES = 20;

    localparam logic [7:0] CH_BANG = "!";
    localparam logic [7:0] CH_Q    = "Q";

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic [7:0] s_char_in = 8'h00;
    logic       m_ready   = 1'b0;

    logic                     s_ready;
    logic                     m_valid;
    logic [CMD_W-1:0]         m_command;
    logic signed [ARG_W-1:0]  m_arg_a;
    logic signed [ARG_W-1:0]  m_arg_b;
    logic                     m_last;

    int fail_count;
    int cmds_waiting;
    int bytes_sent = 0;
    int tx_burst   = 0;
    int rx_burst   = 0;

    logic [7:0] seq_bytes[$];

    // Append one byte to the pending stimulus
    function automatic void add_byte(input logic [7:0] b);
        seq_bytes = {seq_bytes, b};
    endfunction

    ansi_escape_terminal_decoder_unit #(
        .MAX_PARAMS (MAX_PARAMS),
        .VALUE_MAX  (VALUE_MAX)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_char_in (s_char_in),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_command (m_command),
        .m_arg_a   (m_arg_a),
        .m_arg_b   (m_arg_b),
        .m_last    (m_last)
    );

    aetd_cmd_check #(
        .MAX_PARAMS (MAX_PARAMS),
        .VALUE_MAX  (VALUE_MAX)
    ) chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_in    (s_char_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_command    (m_command),
        .m_arg_a      (m_arg_a),
        .m_arg_b      (m_arg_b),
        .m_last       (m_last),
        .fail_count   (fail_count),
        .cmds_waiting (cmds_waiting)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #20_000_000;
        $display("ansi_escape_terminal_decoder_unit test failed");
        $finish;
    end

    // Idle length: mostly none or short, a few long, sometimes a run of none
    task automatic pick_gap(inout int burst, output int n);
        int r;
        r = $urandom_range(0, 99);
        if (burst > 0) begin
            burst--;
            n = 0;
        end else if (r < 4) begin
            burst = $urandom_range(10, 40);
            n = 0;
        end else if (r < 55) begin
            n = 0;
        end else if (r < 88) begin
            n = $urandom_range(1, 3);
        end else if (r < 97) begin
            n = $urandom_range(4, 12);
        end else begin
            n = $urandom_range(20, 60);
        end
    endtask

    // Present one byte and hold it until the beat is taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        pick_gap(tx_burst, gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_char_in <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic flush_seq();
        while (seq_bytes.size() > 0)
            send_byte(seq_bytes.pop_front());
    endtask

    // Hold the sender until every predicted command has been seen
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (cmds_waiting != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_final();
        case ($urandom_range(0, 11))
            0:  return CH_FIN_R;
            1:  return CH_FIN_H;
            2:  return CH_FIN_F;
            3:  return CH_FIN_A;
            4:  return CH_FIN_B;
            5:  return CH_FIN_C;
            6:  return CH_FIN_D;
            7:  return CH_FIN_M;
            8:  return CH_FIN_J;
            9:  return CH_FIN_K;
            10: return CH_FIN_L;
            default: return CH_FIN_DL;
        endcase
    endfunction

    function automatic logic [7:0] any_but_esc();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CH_ESC) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // A byte that is no digit, separator, final or escape
    function automatic logic [7:0] pick_stray();
        logic [7:0] c;
        bit         bad;
        bad = 1'b1;
        c   = 8'h00;
        while (bad) begin
            c = 8'($urandom_range(0, 255));
            bad = (c >= CH_0 && c <= CH_9) || c == CH_SEMI || c == CH_ESC;
            case (c)
                CH_FIN_R, CH_FIN_H, CH_FIN_F, CH_FIN_A, CH_FIN_B, CH_FIN_C,
                CH_FIN_D, CH_FIN_M, CH_FIN_J, CH_FIN_K, CH_FIN_L, CH_FIN_DL: bad = 1'b1;
                default: ;
            endcase
        end
        return c;
    endfunction

    // One parameter: often a meaningful single digit, else a run of digits
    function automatic void push_value();
        int kind;
        int nd;
        int i;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            case ($urandom_range(0, 4))
                0: add_byte(CH_0);
                1: add_byte(CH_0 + 8'd1);
                2: add_byte(CH_0 + 8'd2);
                3: add_byte(CH_0 + 8'd5);
                default: add_byte(CH_0 + 8'd7);
            endcase
        end else begin
            nd = $urandom_range(1, (kind == 9) ? 5 : 3);
            for (i = 0; i < nd; i++)
                add_byte(CH_0 + 8'($urandom_range(0, 9)));
        end
    endfunction

    function automatic void push_values(input int nv);
        int i;
        for (i = 0; i < nv; i++) begin
            if (i > 0)
                add_byte(CH_SEMI);
            if ($urandom_range(0, 11) == 0)
                add_byte(CH_SEMI);
            push_value();
        end
    endfunction

    // ESC [ values final, with an occasional stray byte after the bracket
    function automatic void build_sequence();
        logic [7:0] fin;
        int         r;
        int         nv;
        add_byte(CH_ESC);
        add_byte(CH_LBRK);
        if ($urandom_range(0, 9) == 0)
            add_byte(pick_stray());
        fin = pick_final();
        r   = $urandom_range(0, 9);
        if (fin == CH_FIN_H && r < 6)
            nv = 2;
        else if (r < 2)
            nv = 0;
        else if (r < 8)
            nv = $urandom_range(1, 3);
        else
            nv = $urandom_range(4, 11);
        push_values(nv);
        add_byte(fin);
    endfunction

    // Malformed sequences that stall or get dropped on the next escape
    function automatic void build_broken();
        int i;
        case ($urandom_range(0, 3))
            0: begin
                add_byte(CH_ESC);
                add_byte(pick_stray());
                for (i = $urandom_range(0, 3); i > 0; i--)
                    add_byte(any_but_esc());
                add_byte(CH_ESC);
            end
            1: begin
                add_byte(CH_ESC);
                add_byte(CH_ESC);
            end
            2: begin
                add_byte(CH_ESC);
                add_byte(CH_LBRK);
                push_values($urandom_range(1, 3));
                add_byte(pick_stray());
                for (i = $urandom_range(0, 3); i > 0; i--)
                    add_byte(any_but_esc());
                add_byte(CH_ESC);
            end
            default: begin
                add_byte(CH_ESC);
                add_byte(CH_LBRK);
                push_values($urandom_range(0, 3));
                add_byte(CH_ESC);
            end
        endcase
    endfunction

    function automatic void build_plain();
        int i;
        int r;
        for (i = $urandom_range(1, 6); i > 0; i--) begin
            r = $urandom_range(0, 9);
            if (r == 0)
                add_byte(CH_CR);
            else if (r == 1)
                add_byte(CH_LF);
            else if (r == 2)
                add_byte(CH_DEL);
            else
                add_byte(any_but_esc());
        end
    endfunction

    // Result-side stalls, independent of m_valid
    initial begin : rx_pacing
        int n;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            pick_gap(rx_burst, n);
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // Reset, directed bytes, random traffic, drain and verdict
    initial begin : stimulus
        int r;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // byte extremes, delete, carriage return, line feed
        seq_bytes = '{8'h00, 8'hFF, CH_DEL, CH_CR, CH_LF};
        // every attribute in one sequence
        add_byte(CH_ESC);
        add_byte(CH_LBRK);
        add_byte(CH_0);
        add_byte(CH_SEMI);
        add_byte(CH_0 + 8'd1);
        add_byte(CH_SEMI);
        add_byte(CH_0 + 8'd5);
        add_byte(CH_SEMI);
        add_byte(CH_0 + 8'd7);
        add_byte(CH_FIN_M);
        // stray byte after the bracket, saturated row, zero column
        add_byte(CH_ESC);
        add_byte(CH_LBRK);
        add_byte(CH_BANG);
        add_byte(CH_9);
        add_byte(CH_9);
        add_byte(CH_9);
        add_byte(CH_SEMI);
        add_byte(CH_0);
        add_byte(CH_FIN_H);
        // missing bracket, then escape drops the stalled sequence
        add_byte(CH_ESC);
        add_byte(CH_Q);
        add_byte(CH_ESC);
        flush_seq();
        wait_drained();

        // random traffic, mostly well-formed sequences
        while (bytes_sent < BYTE_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                build_sequence();
            else if (r < 85)
                build_plain();
            else
                build_broken();
            flush_seq();
            if ($urandom_range(0, 29) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("ansi_escape_terminal_decoder_unit test passed");
        else
            $display("ansi_escape_terminal_decoder_unit test failed");
        $finish;
    end

endmodule
